// ----- design/ptrf_pkg.sv -----
package ptrf_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int COMP_W      = 16;
  localparam int NCOMP       = 4;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int KIND_W      = 2;

  typedef logic [NCOMP-1:0][COMP_W-1:0] color_t;

  typedef enum logic [1:0] {
    ACT_READ     = 2'd0,
    ACT_READ_RGB = 2'd1,
    ACT_WRITE    = 2'd2,
    ACT_RAMP     = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRAY = 2'd0,
    KIND_RGB  = 2'd1,
    KIND_CMYK = 2'd2,
    KIND_HLS  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WR_START,
    ST_WR_END,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_STEP,
    ST_DONE
  } state_t;

  // floor quotient and non-negative remainder
  typedef struct packed {
    logic                     done;
    logic signed [COMP_W:0]   quo;
    logic        [IDX_W-1:0]  rem;
  } div_res_t;

endpackage

// ----- design/palette_table_with_ramp_fill.sv -----
// Palette store of ENTRIES colors, four signed 16-bit components each, with a
// grow-only count of entries in use; the valid flags and count clear at
// reset. One beat is taken at a time and the input stalls until its result
// is loaded into the output register. A ramp writes both end colors (only the
// start color when it spans no entries, and with no divider run when it spans
// one), then runs one shared restoring divider once per component to split
// the color step into quotient and remainder, then fills one interior entry
// per cycle. A failing action writes nothing and returns zero components.
module palette_table_with_ramp_fill import ptrf_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [KIND_W-1:0]        cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [IDX_W-1:0]         index,
  input  logic [IDX_W-1:0]         end_index,
  input  logic signed [COMP_W-1:0] comp_one,
  input  logic signed [COMP_W-1:0] comp_two,
  input  logic signed [COMP_W-1:0] comp_three,
  input  logic signed [COMP_W-1:0] comp_four,
  input  logic signed [COMP_W-1:0] end_one,
  input  logic signed [COMP_W-1:0] end_two,
  input  logic signed [COMP_W-1:0] end_three,
  input  logic signed [COMP_W-1:0] end_four,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COMP_W-1:0] out_one,
  output logic signed [COMP_W-1:0] out_two,
  output logic signed [COMP_W-1:0] out_three,
  output logic signed [COMP_W-1:0] out_four,
  output logic                     ok,
  output logic [CNT_W-1:0]         entry_count
);

  localparam int AW = $clog2(ENTRIES);
  localparam int KW = $clog2(NCOMP);
  localparam logic [KW-1:0] KLAST = KW'(NCOMP - 1);

  state_t state, state_next;

  kind_t            kind;
  logic [CNT_W-1:0] count;
  logic             vld [ENTRIES];
  color_t           mem [ENTRIES];

  action_t          act_r;
  logic [AW-1:0]    idx_a;
  logic [AW-1:0]    eidx_a;
  logic [IDX_W-1:0] n_r;
  logic             ok_r;
  color_t           sc;
  color_t           ec;
  color_t           rdata;
  logic             rd_vld;

  logic [KW-1:0]          comp;
  logic signed [COMP_W:0] q  [NCOMP];
  logic [IDX_W-1:0]       r  [NCOMP];
  logic signed [COMP_W:0] dq [NCOMP];
  logic [IDX_W-1:0]       dr [NCOMP];
  logic [AW-1:0]          step_addr;

  logic signed [COMP_W+1:0] q_sum [NCOMP];
  logic signed [COMP_W+1:0] q_nx  [NCOMP];
  logic signed [COMP_W+1:0] q_tr  [NCOMP];
  logic [IDX_W:0]           r_sum [NCOMP];
  logic [IDX_W:0]           r_nx  [NCOMP];
  logic                     wrap  [NCOMP];
  color_t                   lane_val;

  logic             in_fire;
  logic             out_free;
  logic             req_ok;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  color_t           wdata;
  logic             div_start;
  logic signed [COMP_W:0] div_num;
  div_res_t         div;
  color_t           res_val;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (action_t'(action))
      ACT_READ:     req_ok = CNT_W'(index) < count;
      ACT_READ_RGB: req_ok = (CNT_W'(index) < count) && (kind == KIND_RGB);
      ACT_WRITE:    req_ok = CNT_W'(index) < CNT_W'(ENTRIES);
      ACT_RAMP:     req_ok = (index <= end_index) &&
                             (CNT_W'(end_index) < CNT_W'(ENTRIES));
      default:      req_ok = 1'b0;
    endcase
  end

  // ramp lanes: floor quotient q and remainder r of start*n + i*(end-start)
  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      q_sum[k] = (COMP_W+2)'(q[k]) + (COMP_W+2)'(dq[k]);
      r_sum[k] = {1'b0, r[k]} + {1'b0, dr[k]};
      wrap[k]  = r_sum[k] >= {1'b0, n_r};
      q_nx[k]  = q_sum[k] + (COMP_W+2)'(wrap[k]);
      r_nx[k]  = wrap[k] ? (r_sum[k] - {1'b0, n_r}) : r_sum[k];
      q_tr[k]  = (q_nx[k] < 0 && r_nx[k] != '0) ? q_nx[k] + (COMP_W+2)'(1) : q_nx[k];
      lane_val[k] = q_tr[k][COMP_W-1:0];
    end
  end

  assign div_num = (COMP_W+1)'($signed(ec[comp])) - (COMP_W+1)'($signed(sc[comp]));

  ptrf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (n_r),
    .res   (div)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (!req_ok) begin
            state_next = ST_DONE;
          end else if (action == ACT_READ || action == ACT_READ_RGB) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_WR_START;
          end
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_WR_START: begin
        state_next = (act_r == ACT_RAMP && n_r != '0) ? ST_WR_END : ST_DONE;
      end
      ST_WR_END: state_next = (n_r == IDX_W'(1)) ? ST_DONE : ST_DIV_GO;
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div.done) begin
          state_next = (comp == KLAST) ? ST_STEP : ST_DIV_GO;
        end
      end
      ST_STEP: begin
        if (step_addr + AW'(1) == eidx_a) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != ST_IDLE;
    mem_we    = 1'b0;
    waddr     = idx_a;
    wdata     = sc;
    div_start = 1'b0;
    unique case (state)
      ST_WR_START: mem_we = 1'b1;
      ST_WR_END: begin
        mem_we = 1'b1;
        waddr  = eidx_a;
        wdata  = ec;
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_STEP: begin
        mem_we = 1'b1;
        waddr  = step_addr;
        wdata  = lane_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      kind      <= KIND_RGB;
      count     <= '0;
      out_valid <= 1'b0;
      for (int e = 0; e < ENTRIES; e++) begin
        vld[e] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        kind <= kind_t'(cfg_wr_data);
      end
      if (mem_we) begin
        vld[waddr] <= 1'b1;
        if (CNT_W'(waddr) + CNT_W'(1) > count) begin
          count <= CNT_W'(waddr) + CNT_W'(1);
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (state == ST_READ) begin
      rdata  <= mem[idx_a];
      rd_vld <= vld[idx_a];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= action_t'(action);
      idx_a  <= index[AW-1:0];
      eidx_a <= end_index[AW-1:0];
      n_r    <= end_index - index;
      ok_r   <= req_ok;
      sc     <= {comp_four, comp_three, comp_two, comp_one};
      ec     <= {end_four, end_three, end_two, end_one};
    end
    if (state == ST_WR_END) begin
      comp      <= '0;
      step_addr <= idx_a + AW'(1);
      for (int k = 0; k < NCOMP; k++) begin
        q[k] <= (COMP_W+1)'($signed(sc[k]));
        r[k] <= '0;
      end
    end
    if (state == ST_DIV_WAIT && div.done) begin
      dq[comp] <= div.quo;
      dr[comp] <= div.rem;
      comp     <= comp + KW'(1);
    end
    if (state == ST_STEP) begin
      step_addr <= step_addr + AW'(1);
      for (int k = 0; k < NCOMP; k++) begin
        q[k] <= q_nx[k][COMP_W:0];
        r[k] <= r_nx[k][IDX_W-1:0];
      end
    end
  end

  always_comb begin
    if (!ok_r) begin
      res_val = '0;
    end else if (act_r == ACT_READ || act_r == ACT_READ_RGB) begin
      res_val = rd_vld ? rdata : '0;
    end else begin
      res_val = sc;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_one     <= res_val[0];
      out_two     <= res_val[1];
      out_three   <= res_val[2];
      out_four    <= res_val[3];
      ok          <= ok_r;
      entry_count <= count;
    end
  end

endmodule

// ----- design/ptrf_div.sv -----
module ptrf_div import ptrf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [COMP_W:0] num,
  input  logic [IDX_W-1:0]       den,
  output div_res_t               res
);

  localparam int CW = $clog2(COMP_W);
  localparam logic [CW-1:0] LAST = CW'(COMP_W - 1);

  logic              busy;
  logic              done;
  logic [CW-1:0]     cnt;
  logic              neg;
  logic [COMP_W-1:0] quo;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  den_r;

  logic [COMP_W:0]   num_abs;
  logic [IDX_W:0]    rem_sh;
  logic [IDX_W:0]    rem_sub;
  logic              fits;
  logic [COMP_W:0]   q_ext;
  logic              rem_nz;

  always_comb begin
    num_abs = num[COMP_W] ? (-num) : num;
    rem_sh  = {rem, quo[COMP_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num_abs[COMP_W-1:0];
      rem   <= '0;
      neg   <= num[COMP_W];
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[COMP_W-2:0], fits};
      rem <= fits ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];
    end
  end

  always_comb begin
    q_ext    = {1'b0, quo};
    rem_nz   = rem != '0;
    res.done = done;
    if (neg && rem_nz) begin
      res.quo = $signed(-q_ext - (COMP_W+1)'(1));
      res.rem = den_r - rem;
    end else if (neg) begin
      res.quo = $signed(-q_ext);
      res.rem = rem;
    end else begin
      res.quo = $signed(q_ext);
      res.rem = rem;
    end
  end

endmodule
